>>> rtl/rocw_pkg.sv
// Shared types and constants for the rate-of-change window unit.
// Depends on nothing; every other file but rocw_ram refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rocw_pkg;

	localparam int PRICE_W   = 32;
	localparam int TS_W      = 32;
	localparam int PERIOD_W  = 7;
	localparam int FRAC_BITS = 24;
	// Quotient bits kept below the saturation limit (0x7FFFFFFF).
	localparam int QUOT_W    = 31;
	// Headroom between the quotient width and the fraction width.
	localparam int SAT_SHIFT = QUOT_W - FRAC_BITS;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd12;

	typedef enum logic [1:0] {
		ST_NORMAL    = 2'd0,
		ST_WARMUP    = 2'd1,
		ST_ZERO_BASE = 2'd2,
		ST_SATURATED = 2'd3
	} rocw_status_t;

	// One classified item, handed from the front end to the divider.
	typedef struct packed {
		logic [PRICE_W-1:0] price;
		logic [PRICE_W-1:0] base;
		logic [TS_W-1:0]    ts;
		rocw_status_t       kind;
	} rocw_entry_t;

	typedef enum logic {
		F_IDLE,
		F_CLASS
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_PREP,
		B_CHECK,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

`default_nettype wire

>>> rtl/rocw_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rocw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Read returns the old contents when both ports hit the same address.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/rocw_front.sv
// Front end: accepts price items, keeps the price ring, looks up the base
// price and classifies the item. Uses rocw_pkg and rocw_ram.
`timescale 1ns / 1ps
`default_nettype none

module rocw_front #(
	parameter int MAX_PERIOD = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [rocw_pkg::PERIOD_W-1:0]       period,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [rocw_pkg::PRICE_W-1:0]        in_price,
	input  wire logic [rocw_pkg::TS_W-1:0]           in_ts,
	output logic                                     push,
	output rocw_pkg::rocw_entry_t                    push_entry,
	input  wire logic                                q_full
);

	localparam int AW = $clog2(MAX_PERIOD);
	localparam int PW = $clog2(MAX_PERIOD + 1);
	localparam int CW = (PW > rocw_pkg::PERIOD_W) ? PW : rocw_pkg::PERIOD_W;
	localparam int IW = PW + 1;

	rocw_pkg::front_state_t state_q, state_d;

	logic [AW-1:0]                  wp_q;
	logic [PW-1:0]                  seen_q;
	logic [rocw_pkg::PRICE_W-1:0]   price_s1;
	logic [rocw_pkg::TS_W-1:0]      ts_s1;
	logic                           warm_s1;

	logic [CW-1:0]                  per_ext;
	logic [PW-1:0]                  per;
	logic [IW-1:0]                  wp_ext;
	logic [IW-1:0]                  per_i;
	logic [IW-1:0]                  idx;
	logic                           accept;
	logic [rocw_pkg::PRICE_W-1:0]   base;

	// Clamp the period into 1..MAX_PERIOD.
	always_comb begin
		per_ext = CW'(period);
		if (per_ext == '0) begin
			per_ext = CW'(1);
		end else if (per_ext > CW'(MAX_PERIOD)) begin
			per_ext = CW'(MAX_PERIOD);
		end
		per = per_ext[PW-1:0];
	end

	// Slot of the price that lies one period back.
	always_comb begin
		wp_ext = IW'(wp_q);
		per_i  = IW'(per);
		if (wp_ext >= per_i) begin
			idx = wp_ext - per_i;
		end else begin
			idx = wp_ext + IW'(MAX_PERIOD) - per_i;
		end
	end

	assign accept = in_valid && in_ready;

	rocw_ram #(
		.WIDTH(rocw_pkg::PRICE_W),
		.DEPTH(MAX_PERIOD)
	) u_ring (
		.clk  (clk),
		.we   (accept),
		.waddr(wp_q),
		.wdata(in_price),
		.re   (accept),
		.raddr(idx[AW-1:0]),
		.rdata(base)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			rocw_pkg::F_IDLE: begin
				if (in_valid) begin
					state_d = rocw_pkg::F_CLASS;
				end
			end
			rocw_pkg::F_CLASS: begin
				if (!q_full) begin
					state_d = rocw_pkg::F_IDLE;
				end
			end
			default: state_d = rocw_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		push     = 1'b0;
		case (state_q)
			rocw_pkg::F_IDLE:  in_ready = 1'b1;
			rocw_pkg::F_CLASS: push     = !q_full;
			default: begin
				in_ready = 1'b0;
				push     = 1'b0;
			end
		endcase
	end

	always_comb begin
		push_entry.price = price_s1;
		push_entry.base  = base;
		push_entry.ts    = ts_s1;
		if (warm_s1) begin
			push_entry.kind = rocw_pkg::ST_WARMUP;
		end else if (base == '0) begin
			push_entry.kind = rocw_pkg::ST_ZERO_BASE;
		end else begin
			push_entry.kind = rocw_pkg::ST_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rocw_pkg::F_IDLE;
			wp_q    <= '0;
			seen_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				wp_q <= (wp_q == AW'(MAX_PERIOD - 1)) ? '0 : wp_q + AW'(1);
				if (seen_q < PW'(MAX_PERIOD)) begin
					seen_q <= seen_q + PW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			price_s1 <= in_price;
			ts_s1    <= in_ts;
			warm_s1  <= seen_q < per;
		end
	end

endmodule

`default_nettype wire

>>> rtl/rocw_fifo.sv
// Two-entry queue of classified items between front end and divider.
// Uses rocw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rocw_fifo (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire rocw_pkg::rocw_entry_t push_entry,
	output logic                       full,
	input  wire logic                  pop,
	output rocw_pkg::rocw_entry_t      head,
	output logic                       empty
);

	rocw_pkg::rocw_entry_t slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign empty = count_q == 2'd0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/rocw_back.sv
// Back end: restoring divider for (price - base) * 2^24 / base, sign and
// saturation, and the output register. Uses rocw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rocw_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  wire rocw_pkg::rocw_entry_t         q_head,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [rocw_pkg::PRICE_W-1:0]       out_value,
	output logic [rocw_pkg::TS_W-1:0]          out_ts,
	output logic [1:0]                         out_status
);

	localparam int PWID = rocw_pkg::PRICE_W;
	localparam int QW   = rocw_pkg::QUOT_W;
	localparam int SS   = rocw_pkg::SAT_SHIFT;
	localparam int CNTW = $clog2(QW);

	rocw_pkg::back_state_t state_q, state_d;

	rocw_pkg::rocw_entry_t  ent_q;
	rocw_pkg::rocw_status_t stat_q;
	logic [PWID-1:0]        diff_q;
	logic                   neg_q;
	logic [PWID-1:0]        rem_q;
	logic [SS-1:0]          dvd_q;
	logic [QW-1:0]          quo_q;
	logic [CNTW-1:0]        cnt_q;

	logic                   out_valid_q;
	logic [PWID-1:0]        out_value_q;
	logic [rocw_pkg::TS_W-1:0] out_ts_q;
	logic [1:0]             out_status_q;

	logic                   sat;
	logic [PWID:0]          rem_sh;
	logic                   take;
	logic                   load_out;
	logic [PWID-1:0]        value;

	// Quotient exceeds 31 bits exactly when diff >= base * 2^7.
	assign sat = {{SS{1'b0}}, diff_q} >= {ent_q.base, {SS{1'b0}}};

	// One restoring step: shift in the next dividend bit, try the subtract.
	assign rem_sh = {rem_q, dvd_q[SS-1]};
	assign take   = rem_sh >= {1'b0, ent_q.base};

	assign load_out = (state_q == rocw_pkg::B_DONE) && (!out_valid_q || out_ready);
	assign value    = neg_q ? PWID'(-{1'b0, quo_q}) : PWID'({1'b0, quo_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			rocw_pkg::B_IDLE: begin
				if (!q_empty) begin
					state_d = rocw_pkg::B_PREP;
				end
			end
			rocw_pkg::B_PREP:  state_d = rocw_pkg::B_CHECK;
			rocw_pkg::B_CHECK: begin
				if (ent_q.kind != rocw_pkg::ST_NORMAL || sat) begin
					state_d = rocw_pkg::B_DONE;
				end else begin
					state_d = rocw_pkg::B_DIV;
				end
			end
			rocw_pkg::B_DIV: begin
				if (cnt_q == '0) begin
					state_d = rocw_pkg::B_DONE;
				end
			end
			rocw_pkg::B_DONE: begin
				if (load_out) begin
					state_d = rocw_pkg::B_IDLE;
				end
			end
			default: state_d = rocw_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		case (state_q)
			rocw_pkg::B_IDLE: pop = !q_empty;
			default:          pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rocw_pkg::B_IDLE: begin
				if (!q_empty) begin
					ent_q <= q_head;
				end
			end
			rocw_pkg::B_PREP: begin
				neg_q  <= ent_q.price < ent_q.base;
				diff_q <= (ent_q.price >= ent_q.base) ? ent_q.price - ent_q.base
				                                      : ent_q.base - ent_q.price;
			end
			rocw_pkg::B_CHECK: begin
				stat_q <= ent_q.kind;
				rem_q  <= PWID'(diff_q[PWID-1:SS]);
				dvd_q  <= diff_q[SS-1:0];
				cnt_q  <= CNTW'(QW - 1);
				quo_q  <= '0;
				if (ent_q.kind != rocw_pkg::ST_NORMAL) begin
					neg_q <= 1'b0;
				end else if (sat) begin
					neg_q  <= 1'b0;
					quo_q  <= '1;
					stat_q <= rocw_pkg::ST_SATURATED;
				end
			end
			rocw_pkg::B_DIV: begin
				rem_q <= take ? PWID'(rem_sh - {1'b0, ent_q.base}) : rem_sh[PWID-1:0];
				quo_q <= {quo_q[QW-2:0], take};
				dvd_q <= {dvd_q[SS-2:0], 1'b0};
				cnt_q <= cnt_q - CNTW'(1);
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
		if (load_out) begin
			out_value_q  <= value;
			out_ts_q     <= ent_q.ts;
			out_status_q <= stat_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rocw_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_ts     = out_ts_q;
	assign out_status = out_status_q;

endmodule

`default_nettype wire

>>> rtl/rate_of_change_window_unit.sv
// Top level of the rate-of-change window unit: period register, front end,
// queue and divider back end. Uses rocw_pkg, rocw_front, rocw_fifo, rocw_back.
//
// Usage:
//  - s_axis carries one transaction per closing price: tdata holds the price
//    and its timestamp. m_axis returns one transaction per input item:
//    tdata holds the rate of change (signed Q8.24) and the same timestamp,
//    tuser holds the status (normal, warm-up, zero base price, saturated).
//  - cfg_valid/cfg_data write the period (items back to the reference
//    price); cfg_ready is always high. Write it only while the block is
//    idle. A period of 0 acts as 1, one above MAX_PERIOD acts as MAX_PERIOD.
//  - An item passes the front end's classify state, the queue, and the back
//    end's idle, prep and check states; one that runs the division then
//    goes through the divide state, while warm-up, zero-base and saturated
//    items go from check straight to done, which loads the output register.
//  - The divider produces one quotient bit per cycle and takes no new item
//    until the current result has been loaded into the output register.
//  - The front end takes a new item once the last is in the two-entry queue,
//    so it keeps accepting during a division and while a result waits.
//  - Reset clears the pointers, the item count, the queue and the output
//    valid, and sets the period to 12. The price ring needs no clearing.
//  - When the receiver stalls, the output register holds its transaction,
//    the divider waits, the queue fills and then s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module rate_of_change_window_unit #(
	parameter int MAX_PERIOD = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data,       // period
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,   // close_price [31:0], time_stamp [63:32]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,   // roc_value [31:0], time_stamp_out [63:32]
	output logic [7:0]       m_axis_tuser    // status [1:0], zero [7:2]
);

	logic [rocw_pkg::PERIOD_W-1:0] period_q;

	logic                  push;
	logic                  q_full;
	logic                  q_empty;
	logic                  pop;
	rocw_pkg::rocw_entry_t push_entry;
	rocw_pkg::rocw_entry_t q_head;
	logic [1:0]            status;

	// Period register: always ready, write on handshake.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= rocw_pkg::PERIOD_RESET;
		end else if (cfg_valid) begin
			period_q <= cfg_data;
		end
	end

	// Store the price, fetch the base price, classify.
	rocw_front #(
		.MAX_PERIOD(MAX_PERIOD)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.period    (period_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_price  (s_axis_tdata[31:0]),
		.in_ts     (s_axis_tdata[63:32]),
		.push      (push),
		.push_entry(push_entry),
		.q_full    (q_full)
	);

	// Decouple the front end from the divider.
	rocw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (q_full),
		.pop       (pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	// Divide, saturate, present the result.
	rocw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (m_axis_tdata[31:0]),
		.out_ts    (m_axis_tdata[63:32]),
		.out_status(status)
	);

	assign m_axis_tuser = {6'b0, status};

endmodule

`default_nettype wire
